// ===== hw/rtl/rlfs_pkg.sv =====
// package for the linear rgb fade sequencer
// register indexes, mode codes, shared types and the channel step function
package rlfs_pkg;

  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned PASSES_W  = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned PCOUNT_W  = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam logic [PCOUNT_W-1:0] PASS_MAX = {PCOUNT_W{1'b1}};

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FROM_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TO_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PASSES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 3'd4;

  // fade modes; the unused code behaves as once
  localparam logic [MODE_W-1:0] MODE_ONCE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CYCLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_JUMP  = 2'd2;

  typedef struct packed {
    logic [COLOR_W-1:0]  from_color;
    logic [COLOR_W-1:0]  to_color;
    logic [MODE_W-1:0]   fade_mode;
    logic [PASSES_W-1:0] max_passes;
    logic [DELAY_W-1:0]  step_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              start_req;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] window_color;
    logic               stepped;
    logic               done_res;
  } res_t;

  // one unit toward the goal
  function automatic logic [CHAN_W-1:0] toward(input logic [CHAN_W-1:0] cur,
                                               input logic [CHAN_W-1:0] goal);
    logic [CHAN_W-1:0] r;
    if (goal > cur) begin
      r = cur + CHAN_W'(1);
    end else if (goal < cur) begin
      r = cur - CHAN_W'(1);
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rlfs_cfg_regs.sv =====
// configuration register file for the fade sequencer
// depends on rlfs_pkg for register indexes and cfg_t
module rlfs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rlfs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rlfs_pkg::CFG_DAT_W-1:0]  wr_data,
  output rlfs_pkg::cfg_t                  cfg
);

  rlfs_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (wr_index)
        rlfs_pkg::REG_FROM_COLOR: begin
          regs.from_color <= wr_data[rlfs_pkg::COLOR_W-1:0];
        end
        rlfs_pkg::REG_TO_COLOR: begin
          regs.to_color <= wr_data[rlfs_pkg::COLOR_W-1:0];
        end
        rlfs_pkg::REG_FADE_MODE: begin
          regs.fade_mode <= wr_data[rlfs_pkg::MODE_W-1:0];
        end
        rlfs_pkg::REG_MAX_PASSES: begin
          regs.max_passes <= wr_data[rlfs_pkg::PASSES_W-1:0];
        end
        rlfs_pkg::REG_STEP_DELAY: begin
          regs.step_delay_ms <= wr_data[rlfs_pkg::DELAY_W-1:0];
        end
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hw/rtl/rlfs_core.sv =====
// fade state and the per-tick update: timing check, colour step, pass count
// depends on rlfs_pkg for cfg_t, item_t, res_t and toward()
module rlfs_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rlfs_pkg::item_t item,
  input  rlfs_pkg::cfg_t  cfg,
  output rlfs_pkg::res_t  res
);

  logic [rlfs_pkg::CHAN_W-1:0]   cur_red, cur_green, cur_blue;
  logic                          fading_out;
  logic [rlfs_pkg::PCOUNT_W-1:0] pass_count;
  logic [rlfs_pkg::TIME_W-1:0]   last_step_time;
  logic                          done_flag;

  logic [rlfs_pkg::CHAN_W-1:0]   cur_red_next, cur_green_next, cur_blue_next;
  logic                          fading_out_next;
  logic [rlfs_pkg::PCOUNT_W-1:0] pass_count_next;
  logic [rlfs_pkg::TIME_W-1:0]   last_step_time_next;
  logic                          done_flag_next;

  logic [rlfs_pkg::TIME_W-1:0]   elapsed;
  logic                          step_ok;
  logic [rlfs_pkg::COLOR_W-1:0]  goal;
  logic [rlfs_pkg::CHAN_W-1:0]   mv_red, mv_green, mv_blue;
  logic                          reached;
  logic [rlfs_pkg::PCOUNT_W-1:0] pc_inc;
  logic                          done_inc;
  logic                          stepped;

  assign elapsed = item.now_ms - last_step_time;
  assign step_ok = elapsed >= {{(rlfs_pkg::TIME_W-rlfs_pkg::DELAY_W){1'b0}},
                               cfg.step_delay_ms};
  assign goal    = fading_out ? cfg.from_color : cfg.to_color;
  assign mv_red   = rlfs_pkg::toward(cur_red,   goal[23:16]);
  assign mv_green = rlfs_pkg::toward(cur_green, goal[15:8]);
  assign mv_blue  = rlfs_pkg::toward(cur_blue,  goal[7:0]);
  assign reached  = (mv_red == goal[23:16]) && (mv_green == goal[15:8]) &&
                    (mv_blue == goal[7:0]);

  // saturating pass count and the done check that goes with it
  assign pc_inc   = (pass_count == rlfs_pkg::PASS_MAX) ? pass_count
                                                       : pass_count + 1'b1;
  assign done_inc = done_flag ||
                    (pc_inc > {{(rlfs_pkg::PCOUNT_W-rlfs_pkg::PASSES_W){1'b0}},
                               cfg.max_passes});

  always_comb begin
    cur_red_next        = cur_red;
    cur_green_next      = cur_green;
    cur_blue_next       = cur_blue;
    fading_out_next     = fading_out;
    pass_count_next     = pass_count;
    last_step_time_next = last_step_time;
    done_flag_next      = done_flag;
    stepped             = 1'b0;
    if (item.start_req) begin
      cur_red_next        = cfg.from_color[23:16];
      cur_green_next      = cfg.from_color[15:8];
      cur_blue_next       = cfg.from_color[7:0];
      fading_out_next     = 1'b0;
      pass_count_next     = '0;
      last_step_time_next = '0;
      done_flag_next      = 1'b0;
    end else if (step_ok) begin
      stepped             = 1'b1;
      last_step_time_next = item.now_ms;
      cur_red_next        = mv_red;
      cur_green_next      = mv_green;
      cur_blue_next       = mv_blue;
      if (reached) begin
        if (fading_out) begin
          fading_out_next = 1'b0;
          pass_count_next = pc_inc;
          done_flag_next  = done_inc;
        end else if (cfg.fade_mode == rlfs_pkg::MODE_CYCLE) begin
          fading_out_next = 1'b1;
        end else if (cfg.fade_mode == rlfs_pkg::MODE_JUMP) begin
          // counted once, then straight back to the start colour
          pass_count_next = pc_inc;
          done_flag_next  = done_inc;
          cur_red_next    = cfg.from_color[23:16];
          cur_green_next  = cfg.from_color[15:8];
          cur_blue_next   = cfg.from_color[7:0];
        end else begin
          pass_count_next = pc_inc;
          done_flag_next  = done_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_red        <= '0;
      cur_green      <= '0;
      cur_blue       <= '0;
      fading_out     <= 1'b0;
      pass_count     <= '0;
      last_step_time <= '0;
      done_flag      <= 1'b0;
    end else if (advance) begin
      cur_red        <= cur_red_next;
      cur_green      <= cur_green_next;
      cur_blue       <= cur_blue_next;
      fading_out     <= fading_out_next;
      pass_count     <= pass_count_next;
      last_step_time <= last_step_time_next;
      done_flag      <= done_flag_next;
    end
  end

  assign res.window_color = {cur_red_next, cur_green_next, cur_blue_next};
  assign res.stepped      = stepped;
  assign res.done_res     = done_flag_next;

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.start_req |=> pass_count == '0 && !done_flag && !fading_out)
    else $error("start request did not clear the fade state");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag && !(advance && item.start_req) |=> done_flag)
    else $error("done flag fell without a start request");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(advance && item.start_req) |=> pass_count >= $past(pass_count))
    else $error("pass count went down without a start request");

  a_no_step_holds: assert property (@(posedge clk) disable iff (rst)
    advance && !item.start_req && !step_ok |=>
      $stable(cur_red) && $stable(cur_green) && $stable(cur_blue) &&
      $stable(last_step_time))
    else $error("colour or step time moved on a tick without a step");

endmodule

// ===== hw/rtl/rgb_linear_fade_sequencer_top.sv =====
// top level of the linear rgb fade sequencer
// holds the input and result registers; uses rlfs_pkg, rlfs_cfg_regs and rlfs_core
//
//   channel   direction  handshake              payload
//   in        to block   in_valid / in_ready    now_ms, start_req
//   out       from block out_valid / out_ready  window_color, stepped, done_res
//   cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle sustained while the output is not stalled; a request
// waits in the input register; its result is registered as it advances
// the fade state updates as the request moves into the result register
// a stalled result register holds, and the input register takes one more request
// the configuration port is always ready; reset clears the config, fade state and valid flags to zero
module rgb_linear_fade_sequencer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rlfs_pkg::TIME_W-1:0]    now_ms,
  input  logic                           start_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rlfs_pkg::COLOR_W-1:0]   window_color,
  output logic                           stepped,
  output logic                           done_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlfs_pkg::CFG_DAT_W-1:0] cfg_data
);

  rlfs_pkg::cfg_t  cfg;
  rlfs_pkg::item_t item_q;
  rlfs_pkg::res_t  res_d;
  rlfs_pkg::res_t  res_q;
  logic            item_valid;
  logic            advance;

  assign cfg_ready = 1'b1;

  rlfs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // request moves on when the result register is free or being emptied
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.now_ms    <= now_ms;
      item_q.start_req <= start_req;
    end
  end

  rlfs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .res     (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign window_color = res_q.window_color;
  assign stepped      = res_q.stepped;
  assign done_res     = res_q.done_res;

endmodule

// ===== sim/rlfs_fade_checker.sv =====
// scoreboard for the linear rgb fade sequencer: watches the config, tick and colour channels
// keeps its own model of the fade state and compares each result in order; uses rlfs_pkg
`timescale 1ns / 1ps

module rlfs_fade_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [rlfs_pkg::TIME_W-1:0]    now_ms,
  input  logic                           start_req,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [rlfs_pkg::COLOR_W-1:0]   window_color,
  input  logic                           stepped,
  input  logic                           done_res,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rlfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlfs_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);

  logic [rlfs_pkg::COLOR_W-1:0]  cfg_from;
  logic [rlfs_pkg::COLOR_W-1:0]  cfg_to;
  logic [rlfs_pkg::MODE_W-1:0]   cfg_mode;
  logic [rlfs_pkg::PASSES_W-1:0] cfg_max;
  logic [rlfs_pkg::DELAY_W-1:0]  cfg_delay;

  logic [rlfs_pkg::CHAN_W-1:0]   red;
  logic [rlfs_pkg::CHAN_W-1:0]   green;
  logic [rlfs_pkg::CHAN_W-1:0]   blue;
  logic                          fading_out;
  logic [rlfs_pkg::PCOUNT_W-1:0] passes;
  logic [rlfs_pkg::TIME_W-1:0]   last_ms;
  logic                          done;

  rlfs_pkg::res_t window_q[$];

  function automatic logic [rlfs_pkg::CHAN_W-1:0] chan_step(
      input logic [rlfs_pkg::CHAN_W-1:0] cur,
      input logic [rlfs_pkg::CHAN_W-1:0] goal);
    if (cur < goal) begin
      return cur + 1'b1;
    end else if (cur > goal) begin
      return cur - 1'b1;
    end
    return cur;
  endfunction

  // one unit per channel toward goal, true once all three sit on it
  function automatic bit approach(input logic [rlfs_pkg::COLOR_W-1:0] goal);
    red   = chan_step(red, goal[23:16]);
    green = chan_step(green, goal[15:8]);
    blue  = chan_step(blue, goal[7:0]);
    return {red, green, blue} == goal;
  endfunction

  function automatic void bump_passes();
    if (passes != rlfs_pkg::PASS_MAX) begin
      passes = passes + 1'b1;
    end
    if (passes > {1'b0, cfg_max}) begin
      done = 1'b1;
    end
  endfunction

  function automatic rlfs_pkg::res_t fade_tick(input logic [rlfs_pkg::TIME_W-1:0] t,
                                               input logic s);
    rlfs_pkg::res_t r;
    r.stepped = 1'b0;
    if (s) begin
      {red, green, blue} = cfg_from;
      fading_out = 1'b0;
      passes = '0;
      last_ms = '0;
      done = 1'b0;
    end else if (rlfs_pkg::TIME_W'(t - last_ms) >= {16'b0, cfg_delay}) begin
      r.stepped = 1'b1;
      if (!fading_out) begin
        if (approach(cfg_to)) begin
          if (cfg_mode == rlfs_pkg::MODE_CYCLE) begin
            fading_out = 1'b1;
          end else if (cfg_mode == rlfs_pkg::MODE_JUMP) begin
            bump_passes();
            {red, green, blue} = cfg_from;
          end else begin
            // once, and the spare code: counts on every step spent at the target
            bump_passes();
          end
        end
      end else if (approach(cfg_from)) begin
        fading_out = 1'b0;
        bump_passes();
      end
      last_ms = t;
    end
    r.window_color = {red, green, blue};
    r.done_res = done;
    return r;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [rlfs_pkg::COLOR_W-1:0] want,
                                 input logic [rlfs_pkg::COLOR_W-1:0] got);
    $display("%0t mismatch on %s: expected %0h got %0h", $realtime, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    rlfs_pkg::res_t want;
    if (rst) begin
      cfg_from = '0;
      cfg_to = '0;
      cfg_mode = rlfs_pkg::MODE_ONCE;
      cfg_max = '0;
      cfg_delay = '0;
      {red, green, blue} = '0;
      fading_out = 1'b0;
      passes = '0;
      last_ms = '0;
      done = 1'b0;
      window_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rlfs_pkg::REG_FROM_COLOR: cfg_from = cfg_data[rlfs_pkg::COLOR_W-1:0];
          rlfs_pkg::REG_TO_COLOR:   cfg_to = cfg_data[rlfs_pkg::COLOR_W-1:0];
          rlfs_pkg::REG_FADE_MODE:  cfg_mode = cfg_data[rlfs_pkg::MODE_W-1:0];
          rlfs_pkg::REG_MAX_PASSES: cfg_max = cfg_data[rlfs_pkg::PASSES_W-1:0];
          rlfs_pkg::REG_STEP_DELAY: cfg_delay = cfg_data[rlfs_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
      // results leave before the new request is modelled, so a same-cycle pair stays ordered
      if (out_valid && out_ready) begin
        if (window_q.size() == 0) begin
          report_mismatch("unexpected result", '0, window_color);
        end else begin
          want = window_q.pop_front();
          if (window_color !== want.window_color) begin
            report_mismatch("window_color", want.window_color, window_color);
          end
          if (stepped !== want.stepped) begin
            report_mismatch("stepped", rlfs_pkg::COLOR_W'(want.stepped),
                            rlfs_pkg::COLOR_W'(stepped));
          end
          if (done_res !== want.done_res) begin
            report_mismatch("done_res", rlfs_pkg::COLOR_W'(want.done_res),
                            rlfs_pkg::COLOR_W'(done_res));
          end
        end
      end
      if (in_valid && in_ready) begin
        window_q.push_back(fade_tick(now_ms, start_req));
      end
      pending <= window_q.size();
    end
  end

endmodule

// ===== sim/rgb_linear_fade_sequencer_top_test.sv =====
// testbench top for rgb_linear_fade_sequencer_top: clock, reset, config writes and tick requests
// directed fades first, then random phases under varying back-pressure; checking is in rlfs_fade_checker
`timescale 1ns / 1ps

module rgb_linear_fade_sequencer_top_test;

  // first of the unmapped register indexes, and the unused mode code
  localparam logic [rlfs_pkg::CFG_IDX_W-1:0] REG_SPARE  = rlfs_pkg::REG_STEP_DELAY + 3'd1;
  localparam logic [rlfs_pkg::MODE_W-1:0]    MODE_SPARE = rlfs_pkg::MODE_JUMP + 2'd1;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [rlfs_pkg::TIME_W-1:0]    now_ms;
  logic                           start_req;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [rlfs_pkg::COLOR_W-1:0]   window_color;
  logic                           stepped;
  logic                           done_res;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rlfs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rlfs_pkg::CFG_DAT_W-1:0] cfg_data;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [rlfs_pkg::TIME_W-1:0]  clock_ms;
  logic [rlfs_pkg::DELAY_W-1:0] cur_delay;

  rgb_linear_fade_sequencer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .now_ms(now_ms), .start_req(start_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .window_color(window_color), .stepped(stepped), .done_res(done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rlfs_fade_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .now_ms(now_ms), .start_req(start_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .window_color(window_color), .stepped(stepped), .done_res(done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_tick(input logic [rlfs_pkg::TIME_W-1:0] t, input logic s);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    start_req <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // let every outstanding result drain before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rlfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rlfs_pkg::CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_fade(input logic [rlfs_pkg::COLOR_W-1:0] from_c,
                           input logic [rlfs_pkg::COLOR_W-1:0] to_c,
                           input logic [rlfs_pkg::MODE_W-1:0] mode,
                           input logic [rlfs_pkg::PASSES_W-1:0] maxp,
                           input logic [rlfs_pkg::DELAY_W-1:0] delay);
    logic [rlfs_pkg::CFG_DAT_W-1:0] junk;
    // stray bits above the narrow registers now and then, plus the odd unmapped index
    junk = ($urandom_range(3) == 0) ? rlfs_pkg::CFG_DAT_W'($urandom) : '0;
    if ($urandom_range(3) == 0) begin
      write_reg(rlfs_pkg::CFG_IDX_W'(REG_SPARE + $urandom_range(2)),
                rlfs_pkg::CFG_DAT_W'($urandom));
    end
    write_reg(rlfs_pkg::REG_FROM_COLOR, from_c);
    write_reg(rlfs_pkg::REG_TO_COLOR, to_c);
    write_reg(rlfs_pkg::REG_FADE_MODE, {junk[rlfs_pkg::CFG_DAT_W-1:rlfs_pkg::MODE_W], mode});
    write_reg(rlfs_pkg::REG_MAX_PASSES,
              {junk[rlfs_pkg::CFG_DAT_W-1:rlfs_pkg::PASSES_W], maxp});
    write_reg(rlfs_pkg::REG_STEP_DELAY,
              {junk[rlfs_pkg::CFG_DAT_W-1:rlfs_pkg::DELAY_W], delay});
    cfg_valid <= 1'b0;
    cur_delay = delay;
  endtask

  // mostly a start then ticks paced around the step delay, with some time jumps and restarts
  task automatic fade_run(input int n);
    int k;
    int pick;
    logic [rlfs_pkg::TIME_W-1:0] t;
    if ($urandom_range(9) < 8) begin
      send_tick(clock_ms, 1'b1);
    end
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        t = $urandom;
      end else if (pick < 14) begin
        t = clock_ms;
      end else if (pick < 45) begin
        t = clock_ms + cur_delay + $urandom_range(1);
      end else begin
        t = clock_ms + $urandom_range(cur_delay + 1);
      end
      clock_ms = t;
      send_tick(t, $urandom_range(99) < 2);
    end
  endtask

  initial begin
    int k;
    int ph;
    int ch;
    int v;
    logic [rlfs_pkg::COLOR_W-1:0]  f;
    logic [rlfs_pkg::COLOR_W-1:0]  g;
    logic [rlfs_pkg::MODE_W-1:0]   mode;
    logic [rlfs_pkg::PASSES_W-1:0] maxp;
    logic [rlfs_pkg::DELAY_W-1:0]  delay;

    rst = 1'b1;
    in_valid = 1'b0;
    now_ms = '0;
    start_req = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = rlfs_pkg::REG_FROM_COLOR;
    cfg_data = '0;
    clock_ms = '0;
    cur_delay = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // ticks before any start, from black with the reset registers
    send_tick(32'd0, 1'b0);
    send_tick(32'd1, 1'b0);
    drain();

    // channels rising, falling and level; delay honoured; once mode keeps counting at target
    load_fade(24'h010203, 24'h030201, rlfs_pkg::MODE_ONCE, 16'd0, 16'd2);
    send_tick('1, 1'b1);
    send_tick(32'd1, 1'b0);
    send_tick(32'd2, 1'b0);
    send_tick(32'd4, 1'b0);
    send_tick(32'd6, 1'b0);
    send_tick(32'd8, 1'b0);
    drain();

    // back and forth twice, done once the second pass exceeds the maximum
    load_fade(24'h000000, 24'h020202, rlfs_pkg::MODE_CYCLE, 16'd1, 16'd0);
    send_tick(32'd100, 1'b1);
    for (k = 0; k < 9; k++) begin
      send_tick(32'd101 + k, 1'b0);
    end
    drain();

    load_fade(24'hffffff, 24'hfefefe, rlfs_pkg::MODE_JUMP, 16'd0, 16'd0);
    send_tick(32'd7, 1'b1);
    send_tick(32'd8, 1'b0);
    send_tick(32'd9, 1'b0);
    drain();

    // spare mode code, longest delay, time wrapping past zero
    load_fade(24'h000000, 24'h000001, MODE_SPARE, 16'hffff, 16'hffff);
    send_tick(32'd0, 1'b1);
    send_tick(32'd65534, 1'b0);
    send_tick(32'd65535, 1'b0);
    send_tick(32'hffff_fff0, 1'b0);
    send_tick(32'h0000_0010, 1'b0);
    drain();

    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (ph == 3) begin
        load_fade(24'h000000, 24'hffffff, rlfs_pkg::MODE_CYCLE, 16'hffff, 16'd0);
      end else if (ph == 7) begin
        load_fade(24'hffffff, 24'h000000, rlfs_pkg::MODE_JUMP, 16'd0, 16'hffff);
      end else begin
        // short fades so that many passes complete
        f = rlfs_pkg::COLOR_W'($urandom);
        for (ch = 0; ch < 3; ch++) begin
          v = int'(f[ch*8 +: 8]) + int'($urandom_range(8)) - 4;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          g[ch*8 +: 8] = rlfs_pkg::CHAN_W'(v);
        end
        mode = rlfs_pkg::MODE_W'($urandom_range(3));
        v = $urandom_range(9);
        maxp = (v == 0) ? 16'd0 : (v == 1) ? 16'hffff
                                           : rlfs_pkg::PASSES_W'($urandom_range(5));
        v = $urandom_range(9);
        delay = (v == 0) ? 16'hffff : (v == 1) ? rlfs_pkg::DELAY_W'($urandom)
                                               : rlfs_pkg::DELAY_W'($urandom_range(3));
        load_fade(f, g, mode, maxp, delay);
      end
      fade_run(135);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== rgb_linear_fade_sequencer_top.f =====
hw/rtl/rlfs_pkg.sv
hw/rtl/rlfs_cfg_regs.sv
hw/rtl/rlfs_core.sv
hw/rtl/rgb_linear_fade_sequencer_top.sv
sim/rlfs_fade_checker.sv
sim/rgb_linear_fade_sequencer_top_test.sv
